// File: src/yaz0_decompressor_with_skip_top_macros.svh
// Assertion helpers used by the packer.
`ifndef YAZ0_DECOMPRESSOR_WITH_SKIP_TOP_MACROS_SVH
`define YAZ0_DECOMPRESSOR_WITH_SKIP_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define YZ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the following cycle.
`define YZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/yaz0ds_pkg.sv
// ----------------------------------------------------------------------------
// yaz0ds_pkg
// Shared types and constants of the Yaz0 decoder.
// ----------------------------------------------------------------------------
package yaz0ds_pkg;

  localparam int unsigned HeaderLast = 4'h0f;
  localparam int unsigned LongBias   = 8'h12;

  localparam logic [7:0] CfgSkip = 8'd0;
  localparam logic [7:0] CfgMaxo = 8'd1;

  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic       end_s;
    logic       bad;
  } pk_req_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h59;
      2'd1:    m = 8'h61;
      2'd2:    m = 8'h7a;
      default: m = 8'h30;
    endcase
    return m;
  endfunction

endpackage

// File: src/yaz0ds_history.sv
// ----------------------------------------------------------------------------
// yaz0ds_history
// History ring: one write and one registered read per cycle. A fill pointer
// and wrap flag make entries not yet written since restart read as zero.
// ----------------------------------------------------------------------------
module yaz0ds_history #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          we_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] wptr_o,
  output logic [7:0]    rdata_o
);
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic          full_q, full_d;
  logic [7:0]    rdata_q;
  logic          rvalid_q;

  always_comb begin
    wptr_d = wptr_q;
    full_d = full_q;
    if (clr_i) begin
      wptr_d = '0;
      full_d = 1'b0;
    end else if (we_i) begin
      if (wptr_q == AW'(DEPTH - 1)) begin
        wptr_d = '0;
        full_d = 1'b1;
      end else begin
        wptr_d = wptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      full_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      full_q <= full_d;
      if (re_i) rvalid_q <= full_q || (raddr_i < wptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem[wptr_q] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign wptr_o  = wptr_q;
  assign rdata_o = rvalid_q ? rdata_q : 8'h00;
endmodule

// File: src/yaz0ds_packer.sv
// ----------------------------------------------------------------------------
// yaz0ds_packer
// Packs decoded bytes into results and holds one result for the output side.
// ----------------------------------------------------------------------------
module yaz0ds_packer #(
  parameter int unsigned PACK_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  yaz0ds_pkg::pk_req_t req_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         out_bytes_o,
  output logic [3:0]          byte_count_o,
  output logic                last_of_run_o,
  output logic                stream_end_o,
  output logic                bad_magic_o,
  output logic [31:0]         total_out_o
);
  import yaz0ds_pkg::*;

  localparam int unsigned CW = $clog2(PACK_BYTES + 1);

  logic [7:0]    acc_q [PACK_BYTES];
  logic [7:0]    acc_n [PACK_BYTES];
  logic [CW-1:0] cnt_q, cnt_n;
  logic [31:0]   tot_q, tot_n;
  logic          ov_q;
  logic          out_free, emit, fire;
  logic [63:0]   packed_n;

  assign out_free = !ov_q || out_ready_i;
  assign emit     = req_i.valid && (!req_i.has_byte || req_i.last ||
                    cnt_q == CW'(PACK_BYTES - 1));
  assign ready_o  = !emit || out_free;
  assign fire     = req_i.valid && ready_o;

  always_comb begin
    packed_n = '0;
    for (int i = 0; i < PACK_BYTES; i++) begin
      acc_n[i] = acc_q[i];
      if (req_i.has_byte && cnt_q == CW'(i)) acc_n[i] = req_i.data;
      packed_n[8*i +: 8] = acc_n[i];
    end
    cnt_n = cnt_q + CW'(req_i.has_byte);
    tot_n = tot_q + 32'(cnt_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      cnt_q <= '0;
      tot_q <= '0;
      for (int i = 0; i < PACK_BYTES; i++) acc_q[i] <= 8'h00;
    end else begin
      if (out_ready_i) ov_q <= 1'b0;
      if (clr_i) tot_q <= '0;
      if (fire) begin
        if (emit) begin
          ov_q  <= 1'b1;
          cnt_q <= '0;
          tot_q <= tot_n;
          for (int i = 0; i < PACK_BYTES; i++) acc_q[i] <= 8'h00;
        end else begin
          cnt_q <= cnt_n;
          for (int i = 0; i < PACK_BYTES; i++) acc_q[i] <= acc_n[i];
        end
      end
    end
  end

  // Result register: payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_bytes_o   <= packed_n;
      byte_count_o  <= 4'(cnt_n);
      last_of_run_o <= req_i.last || !req_i.has_byte;
      stream_end_o  <= req_i.end_s;
      bad_magic_o   <= req_i.bad;
      total_out_o   <= tot_n;
    end
  end

  assign out_valid_o = ov_q;

  `include "yaz0_decompressor_with_skip_top_macros.svh"
  `YZ_ASSERT_NOW(a_bad_empty, ov_q && bad_magic_o, byte_count_o == 4'd0 && !stream_end_o)
  `YZ_ASSERT_NOW(a_data_nonempty, ov_q && !bad_magic_o && !stream_end_o, byte_count_o != 4'd0)
  `YZ_ASSERT_NEXT(a_hold, ov_q && !out_ready_i, ov_q && $stable(total_out_o))
endmodule

// File: src/yaz0_decompressor_with_skip_top.sv
// A literal is held in a register and goes to the packer in the byte state;
// a back reference reads history, then writes it, for each copied byte.
// No new input byte is taken while a literal or reference is in progress,
// and the packer can stall it; the history has a single read/write port pair.
// Reset clears all control state; the history reads as zero until written,
// tracked by a fill pointer, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// yaz0_decompressor_with_skip_top
// Yaz0 stream decoder with leading skip and output cap.
// ----------------------------------------------------------------------------
module yaz0_decompressor_with_skip_top #(
  parameter int unsigned HISTORY_DEPTH = 4096,
  parameter int unsigned PACK_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        first_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_run_o,
  output logic        stream_end_o,
  output logic        bad_magic_o,
  output logic [31:0] total_out_o
);
  import yaz0ds_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_FLAG   = 7'b0000010,
    PH_LIT    = 7'b0000100,
    PH_REF1   = 7'b0001000,
    PH_REF2   = 7'b0010000,
    PH_REF3   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  typedef enum logic [3:0] {
    ST_ACCEPT  = 4'b0001,
    ST_READ    = 4'b0010,
    ST_BYTE    = 4'b0100,
    ST_SPECIAL = 4'b1000
  } st_e;

  phase_e        phase_q, phase_d, ph;
  st_e           st_q, st_d;
  logic [3:0]    hidx_q, hidx_d, hidx;
  logic [31:0]   slen_q, slen_d, slen;
  logic [7:0]    flags_q, flags_d;
  logic [3:0]    left_q, left_d;
  logic [7:0]    r1_q, r1_d, r2_q, r2_d;
  logic [31:0]   dec_q, dec_d, emit_q, emit_d, lim_q, lim_d;
  logic [31:0]   skip_q, maxo_q;
  logic [7:0]    cur_q, cur_d;
  logic          lit_q, lit_d, bad_q, bad_d;
  logic [8:0]    left_cp_q, left_cp_d;
  logic [AW-1:0] src_q, src_d;

  logic          in_fire, restart, skip, ended, final_b, progress;
  logic [7:0]    cur_b, flags_n;
  logic [3:0]    left_n;
  logic [31:0]   lim_c;
  logic [11:0]   ref_dist;
  logic [AW:0]   src_c;
  logic [AW-1:0] wptr;
  logic [7:0]    hist_rdata;
  logic          hist_we;
  logic          pk_ready;
  pk_req_t       req;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      maxo_q <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSkip) skip_q <= cfg_data_i;
      else if (cfg_index_i == CfgMaxo) maxo_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (st_q == ST_ACCEPT);
  assign in_fire    = in_valid_i && in_ready_o;
  assign restart    = in_fire && first_of_stream_i;

  assign cur_b   = lit_q ? cur_q : hist_rdata;
  assign skip    = dec_q < skip_q;
  assign ended   = !skip && (emit_q + 32'd1 >= lim_q);
  assign final_b = lit_q || (left_cp_q == 9'd1);
  assign progress = (st_q == ST_BYTE) && (skip || pk_ready);
  assign hist_we = progress;
  assign flags_n = {flags_q[6:0], 1'b0};
  assign left_n  = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
  assign lim_c   = (slen > skip_q) ? slen - skip_q : 32'd0;

  always_comb begin
    ph   = first_of_stream_i ? PH_HEADER : phase_q;
    hidx = first_of_stream_i ? 4'd0 : hidx_q;
    slen = first_of_stream_i ? 32'd0 : slen_q;
    if (hidx >= 4'd4 && hidx < 4'd8) slen = {slen[23:0], in_byte_i};
    ref_dist = (ph == PH_REF2) ? {r1_q[3:0], in_byte_i} : {r1_q[3:0], r2_q};
    src_c = {1'b0, wptr} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(ref_dist) - (AW+1)'(1);
    if (src_c >= (AW+1)'(HISTORY_DEPTH)) src_c = src_c - (AW+1)'(HISTORY_DEPTH);
  end

  always_comb begin
    phase_d   = phase_q;
    st_d      = st_q;
    hidx_d    = hidx_q;
    slen_d    = slen_q;
    flags_d   = flags_q;
    left_d    = left_q;
    r1_d      = r1_q;
    r2_d      = r2_q;
    dec_d     = dec_q;
    emit_d    = emit_q;
    lim_d     = lim_q;
    cur_d     = cur_q;
    lit_d     = lit_q;
    bad_d     = bad_q;
    left_cp_d = left_cp_q;
    src_d     = src_q;
    req       = '0;
    case (st_q)
      ST_ACCEPT: begin
        if (in_fire) begin
          if (restart) begin
            phase_d = PH_HEADER;
            hidx_d  = 4'd0;
            slen_d  = '0;
            flags_d = '0;
            left_d  = '0;
            r1_d    = '0;
            r2_d    = '0;
            dec_d   = '0;
            emit_d  = '0;
            lim_d   = '0;
          end
          case (ph)
            PH_HEADER: begin
              if (hidx < 4'd4 && in_byte_i != magic_byte(hidx[1:0])) begin
                phase_d = PH_DONE;
                st_d    = ST_SPECIAL;
                bad_d   = 1'b1;
              end else begin
                slen_d = slen;
                if (hidx == 4'(HeaderLast)) begin
                  hidx_d = hidx;
                  lim_d  = (lim_c > maxo_q) ? maxo_q : lim_c;
                  if (lim_d == 32'd0) begin
                    phase_d = PH_DONE;
                    st_d    = ST_SPECIAL;
                    bad_d   = 1'b0;
                  end else begin
                    phase_d = PH_FLAG;
                  end
                end else begin
                  hidx_d = hidx + 4'd1;
                end
              end
            end
            PH_FLAG: begin
              flags_d = in_byte_i;
              left_d  = 4'd8;
              phase_d = in_byte_i[7] ? PH_LIT : PH_REF1;
            end
            PH_LIT: begin
              cur_d = in_byte_i;
              lit_d = 1'b1;
              st_d  = ST_BYTE;
            end
            PH_REF1: begin
              r1_d    = in_byte_i;
              phase_d = PH_REF2;
            end
            PH_REF2: begin
              r2_d = in_byte_i;
              if (r1_q[7:4] == 4'd0) begin
                phase_d = PH_REF3;
              end else begin
                left_cp_d = 9'(r1_q[7:4]) + 9'd2;
                src_d     = src_c[AW-1:0];
                lit_d     = 1'b0;
                st_d      = ST_READ;
              end
            end
            PH_REF3: begin
              left_cp_d = 9'(in_byte_i) + 9'(LongBias);
              src_d     = src_c[AW-1:0];
              lit_d     = 1'b0;
              st_d      = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: st_d = ST_BYTE;
      ST_BYTE: begin
        req.valid    = !skip;
        req.has_byte = 1'b1;
        req.data     = cur_b;
        req.last     = final_b || ended;
        req.end_s    = ended;
        if (progress) begin
          if (skip) dec_d = dec_q + 32'd1;
          else emit_d = emit_q + 32'd1;
          if (ended) begin
            phase_d = PH_DONE;
            st_d    = ST_ACCEPT;
          end else if (!final_b) begin
            left_cp_d = left_cp_q - 9'd1;
            src_d     = (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + AW'(1);
            st_d      = ST_READ;
          end else begin
            flags_d = flags_n;
            left_d  = left_n;
            phase_d = (left_n == 4'd0) ? PH_FLAG : (flags_n[7] ? PH_LIT : PH_REF1);
            st_d    = ST_ACCEPT;
          end
        end
      end
      ST_SPECIAL: begin
        req.valid = 1'b1;
        req.last  = 1'b1;
        req.end_s = !bad_q;
        req.bad   = bad_q;
        if (pk_ready) st_d = ST_ACCEPT;
      end
      default: st_d = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      st_q      <= ST_ACCEPT;
      hidx_q    <= '0;
      slen_q    <= '0;
      flags_q   <= '0;
      left_q    <= '0;
      r1_q      <= '0;
      r2_q      <= '0;
      dec_q     <= '0;
      emit_q    <= '0;
      lim_q     <= '0;
      lit_q     <= 1'b0;
      bad_q     <= 1'b0;
      left_cp_q <= '0;
      src_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      st_q      <= st_d;
      hidx_q    <= hidx_d;
      slen_q    <= slen_d;
      flags_q   <= flags_d;
      left_q    <= left_d;
      r1_q      <= r1_d;
      r2_q      <= r2_d;
      dec_q     <= dec_d;
      emit_q    <= emit_d;
      lim_q     <= lim_d;
      lit_q     <= lit_d;
      bad_q     <= bad_d;
      left_cp_q <= left_cp_d;
      src_q     <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  yaz0ds_history #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (restart),
    .we_i   (hist_we),
    .wdata_i(cur_b),
    .re_i   (st_q == ST_READ),
    .raddr_i(src_q),
    .wptr_o (wptr),
    .rdata_o(hist_rdata)
  );

  yaz0ds_packer #(
    .PACK_BYTES(PACK_BYTES)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (restart),
    .req_i        (req),
    .ready_o      (pk_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_bytes_o  (out_bytes_o),
    .byte_count_o (byte_count_o),
    .last_of_run_o(last_of_run_o),
    .stream_end_o (stream_end_o),
    .bad_magic_o  (bad_magic_o),
    .total_out_o  (total_out_o)
  );
endmodule

// File: tb/sv/yaz0_decompressor_with_skip_top_test.sv
// ----------------------------------------------------------------------------
// yaz0_decompressor_with_skip_top_test
// Drives Yaz0 streams (good, broken and truncated) through the decoder under
// several skip and cap settings and idle patterns. A built-in decoder model
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module yaz0_decompressor_with_skip_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import yaz0ds_pkg::*;

  localparam int unsigned HistDepth  = 4096;
  localparam int unsigned PackBytes  = 8;
  localparam int unsigned MaxRun     = 273;
  localparam int unsigned SettleCyc  = 700;
  localparam longint      CycleLimit = 1000000;

  typedef enum logic [2:0] {
    PH_HEADER, PH_FLAG, PH_LIT, PH_REF1, PH_REF2, PH_REF3, PH_DONE
  } dec_phase_e;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        end_s;
    logic        bad;
    logic [31:0] tot;
  } yz_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        first_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_bytes_o;
  logic [3:0]  byte_count_o;
  logic        last_of_run_o;
  logic        stream_end_o;
  logic        bad_magic_o;
  logic [31:0] total_out_o;

  yaz0_decompressor_with_skip_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder model state
  logic [31:0] skip_reg, maxo_reg;
  dec_phase_e  dec_phase;
  int          hdr_idx;
  logic [31:0] str_len;
  logic [7:0]  flags;
  logic [3:0]  flags_left;
  logic [7:0]  ref_b1, ref_b2;
  logic [7:0]  hist [HistDepth];
  logic [11:0] hist_ptr;
  logic [31:0] decoded_cnt, emitted_cnt, out_limit;
  logic [7:0]  run_q [$];
  bit          run_ended;

  yz_result_t  expected_q [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;

  function automatic void restart_decoder();
    dec_phase = PH_HEADER;
    hdr_idx = 0;
    str_len = '0;
    flags = '0;
    flags_left = '0;
    ref_b1 = '0;
    ref_b2 = '0;
    foreach (hist[i]) hist[i] = '0;
    hist_ptr = '0;
    decoded_cnt = '0;
    emitted_cnt = '0;
    out_limit = '0;
  endfunction

  function automatic bit store_decoded(logic [7:0] b);
    hist[hist_ptr] = b;
    hist_ptr++;
    if (decoded_cnt < skip_reg) begin
      decoded_cnt++;
      return 1'b0;
    end
    if (emitted_cnt < out_limit && run_q.size() < MaxRun) begin
      run_q.push_back(b);
      emitted_cnt++;
    end
    return emitted_cnt >= out_limit;
  endfunction

  function automatic void copy_back(int unsigned len);
    logic [11:0] src;
    src = hist_ptr - {ref_b1[3:0], ref_b2} - 12'd1;
    for (int unsigned i = 0; i < len; i++) begin
      if (store_decoded(hist[src])) begin
        run_ended = 1'b1;
        return;
      end
      src++;
    end
  endfunction

  function automatic void advance_element();
    flags = flags << 1;
    if (flags_left > 0) flags_left--;
    if (flags_left == 0) dec_phase = PH_FLAG;
    else dec_phase = flags[7] ? PH_LIT : PH_REF1;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic first);
    logic [7:0] magic [4];
    yz_result_t r;
    int unsigned pos, n;
    magic = '{8'h59, 8'h61, 8'h7a, 8'h30};
    if (first) restart_decoder();
    run_q.delete();
    run_ended = 1'b0;
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_idx < 4) begin
          if (b != magic[hdr_idx]) begin
            dec_phase = PH_DONE;
            expected_q.push_back('{64'd0, 4'd0, 1'b1, 1'b0, 1'b1, 32'd0});
            return;
          end
        end else if (hdr_idx < 8) begin
          str_len = {str_len[23:0], b};
        end
        hdr_idx++;
        if (hdr_idx > HeaderLast) begin
          hdr_idx = HeaderLast;
          out_limit = (str_len > skip_reg) ? str_len - skip_reg : 32'd0;
          if (out_limit > maxo_reg) out_limit = maxo_reg;
          if (out_limit == 0) begin
            dec_phase = PH_DONE;
            expected_q.push_back('{64'd0, 4'd0, 1'b1, 1'b1, 1'b0, 32'd0});
            return;
          end
          dec_phase = PH_FLAG;
        end
        return;
      end
      PH_FLAG: begin
        flags = b;
        flags_left = 4'd8;
        dec_phase = b[7] ? PH_LIT : PH_REF1;
        return;
      end
      PH_LIT: begin
        run_ended = store_decoded(b);
        advance_element();
      end
      PH_REF1: begin
        ref_b1 = b;
        dec_phase = PH_REF2;
        return;
      end
      PH_REF2: begin
        ref_b2 = b;
        if (ref_b1[7:4] == 0) begin
          dec_phase = PH_REF3;
          return;
        end
        copy_back(ref_b1[7:4] + 2);
        advance_element();
      end
      PH_REF3: begin
        copy_back(b + LongBias);
        advance_element();
      end
      default: return;
    endcase
    if (run_ended) dec_phase = PH_DONE;
    pos = 0;
    while (pos < run_q.size()) begin
      n = run_q.size() - pos;
      if (n > PackBytes) n = PackBytes;
      r = '0;
      for (int unsigned i = 0; i < n; i++) r.bytes[8*i +: 8] = run_q[pos + i];
      pos += n;
      r.cnt = 4'(n);
      r.last = (pos >= run_q.size());
      r.end_s = r.last && run_ended;
      r.tot = 32'(emitted_cnt - run_q.size() + pos);
      expected_q.push_back(r);
    end
  endfunction

  // receiver side: stall at random per the current setting
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    yz_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_bytes_o, byte_count_o, last_of_run_o, stream_end_o, bad_magic_o,
              total_out_o};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.bytes !== want.bytes)
          $display("%0t: out_bytes expected %h actual %h", $time, want.bytes, got.bytes);
        if (got.cnt !== want.cnt)
          $display("%0t: byte_count expected %0d actual %0d", $time, want.cnt, got.cnt);
        if (got.last !== want.last)
          $display("%0t: last_of_run expected %b actual %b", $time, want.last, got.last);
        if (got.end_s !== want.end_s)
          $display("%0t: stream_end expected %b actual %b", $time, want.end_s, got.end_s);
        if (got.bad !== want.bad)
          $display("%0t: bad_magic expected %b actual %b", $time, want.bad, got.bad);
        if (got.tot !== want.tot)
          $display("%0t: total_out expected %0d actual %0d", $time, want.tot, got.tot);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold valid high back to back; lower it only on an idle cycle
  task automatic send_byte(logic [7:0] b, logic first = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    first_of_stream_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, first);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgSkip) skip_reg = data;
    else if (idx == CfgMaxo) maxo_reg = data;
  endtask

  task automatic configure(logic [31:0] skip, logic [31:0] maxo);
    drain();
    write_reg(CfgSkip, skip);
    write_reg(CfgMaxo, maxo);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // bad_pos selects a magic byte to corrupt, or none when out of 0..3;
  // a corrupted header stops at the bad byte
  task automatic send_header(logic [31:0] len, logic first = 1'b1, int bad_pos = -1);
    logic [7:0] hb [16];
    hb[0] = 8'h59; hb[1] = 8'h61; hb[2] = 8'h7a; hb[3] = 8'h30;
    hb[4] = len[31:24]; hb[5] = len[23:16]; hb[6] = len[15:8]; hb[7] = len[7:0];
    for (int i = 8; i < 16; i++) hb[i] = 8'($urandom);
    if (bad_pos >= 0 && bad_pos < 4) hb[bad_pos] = hb[bad_pos] ^ (8'h1 << $urandom_range(7));
    for (int i = 0; i < 16; i++) begin
      send_byte(hb[i], first && i == 0);
      if (i == bad_pos) break;
    end
  endtask

  // random flag groups until the stream ends or max_items bytes went out
  task automatic send_body(int max_items, int long_pct = 5);
    logic [7:0] fl;
    int n;
    n = 0;
    while (dec_phase != PH_DONE && dec_phase != PH_HEADER && n < max_items) begin
      fl = 8'($urandom);
      send_byte(fl); n++;
      for (int i = 7; i >= 0 && dec_phase != PH_DONE && n < max_items; i--) begin
        if (fl[i]) begin
          send_byte(8'($urandom)); n++;
        end else begin
          if ($urandom_range(99) < long_pct) begin
            send_byte({4'h0, 4'($urandom)});
            send_byte(8'($urandom));
            send_byte($urandom_range(3) == 0 ? 8'hff : 8'($urandom_range(30)));
            n += 3;
          end else begin
            send_byte({4'($urandom_range(15, 1)), 4'($urandom_range(1) ? 0 : $urandom)});
            send_byte(8'($urandom));
            n += 2;
          end
        end
      end
    end
  endtask

  task automatic test_no_restart_mark();
    send_header(32'd12, 1'b0);
    send_byte(8'hff);
    for (int i = 0; i < 8; i++) send_byte(8'(8'h41 + i));
    send_byte(8'h00);
    send_byte(8'h10);
    send_byte(8'h07);
    send_byte(8'h21);
  endtask

  task automatic test_bad_magic();
    for (int p = 0; p < 4; p++) begin
      send_header(32'd20, 1'b1, p);
      send_byte(8'($urandom));
    end
  endtask

  task automatic test_zero_limit();
    send_header(32'd0);
    send_byte(8'hff);
    configure(32'hffff_ffff, 32'hffff_ffff);
    send_header(32'd40);
  endtask

  task automatic test_long_reference();
    configure(32'd0, 32'hffff_ffff);
    send_header(32'd600);
    send_byte(8'h40);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h5a);
    send_byte(8'h0f);
    send_byte(8'hff);
    send_byte(8'hff);
    send_body(4, 30);
  endtask

  task automatic test_skip_and_cap();
    configure(32'd5, 32'd7);
    send_header(32'd30);
    send_body(12);
    send_byte(8'hff);
    send_byte(8'h00);
    drain();
  endtask

  // one long stream carried through every idle and stall pattern
  task automatic test_random();
    int settings [4][2];
    settings = '{'{0, 0}, '{67, 0}, '{0, 67}, '{38, 38}};
    configure(32'($urandom_range(20)), 32'hffff_ffff);
    send_header(32'd5000);
    foreach (settings[p]) begin
      idle_pct = settings[p][0];
      stall_pct = settings[p][1];
      send_body(6, 10);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    skip_reg = '0;
    maxo_reg = 32'hffff_ffff;
    restart_decoder();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_restart_mark();
    test_bad_magic();
    test_zero_limit();
    test_long_reference();
    test_skip_and_cap();
    test_random();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: yaz0_decompressor_with_skip_top.f
+incdir+src
src/yaz0ds_pkg.sv
src/yaz0ds_history.sv
src/yaz0ds_packer.sv
src/yaz0_decompressor_with_skip_top.sv
tb/sv/yaz0_decompressor_with_skip_top_test.sv
